>>> src/tdhs_pkg.sv
// shared types and constants for the timer heap scheduler
`timescale 1ns / 1ps
`default_nettype none
package tdhs_pkg;
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_SERVICE = 2'd2;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_PERIODIC = 3'd3;
  localparam logic [2:0] ST_ONESHOT  = 3'd4;
  localparam logic [2:0] ST_STALE    = 3'd5;

  localparam logic [36:0] MAX_SPAN_MS = 37'd86400000000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  timer_id;
    logic [36:0] delay_ms;
    logic [36:0] period_ms;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  fired_timer;
    logic [63:0] fire_time;
    logic [31:0] entry_serial;
  } out_beat_t;

  // one heap slot as stored in memory
  typedef struct packed {
    logic [63:0] deadline;
    logic [36:0] period;
    logic [5:0]  handle;
    logic [31:0] serial;
  } heap_entry_t;
endpackage
`default_nettype wire

>>> src/tdhs_in_if.sv
// input command channel
`timescale 1ns / 1ps
`default_nettype none
interface tdhs_in_if import tdhs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/tdhs_out_if.sv
// result channel
`timescale 1ns / 1ps
`default_nettype none
interface tdhs_out_if import tdhs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/timer_deadline_heap_scheduler_unit.sv
// timer scheduler top level: min-heap of deadlines held in block memory
`timescale 1ns / 1ps
`default_nettype none
// Timer queue keeping pending timers in a binary min-heap held in one
// synchronous memory (deadline, period, handle, serial per slot), plus a
// handle-serial memory with valid bits. One command at a time. The result of
// a tick, a reject or a service on an empty heap is valid in the cycle after
// the beat is taken. A service whose root is not yet due ends once the root
// is read and its deadline compared. An insert climbs by parent read and
// compare per level. A service that pops checks the handle serial, moves the
// last entry to the root and sinks it by left read, right read and compare
// per level. The next command is taken in the cycle after the result beat
// leaves. Each level reads a parent or two children through the single heap
// memory port pair, compares, and writes back. Entries tie on deadline by
// lower serial. Writing cfg_wdata to the seed register reloads the serial
// counter.
module timer_deadline_heap_scheduler_unit
  import tdhs_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 64,
  parameter int TIMER_HANDLES = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  tdhs_in_if.sink     in_ch,
  tdhs_out_if.source  out_ch,
  input  wire         cfg_we,
  input  wire  [31:0] cfg_wdata
);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int HW = (TIMER_HANDLES > 1) ? $clog2(TIMER_HANDLES) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UPRD  = 4'd1;  // read parent
  localparam logic [3:0] S_UPCMP = 4'd2;  // compare with parent
  localparam logic [3:0] S_SRD   = 4'd3;  // root read issued
  localparam logic [3:0] S_SHS   = 4'd4;  // check root, handle serial
  localparam logic [3:0] S_LAST  = 4'd5;  // last entry read
  localparam logic [3:0] S_DNL   = 4'd6;  // read left child
  localparam logic [3:0] S_DNR   = 4'd7;  // left data ready, read right
  localparam logic [3:0] S_DNCMP = 4'd8;  // right data ready
  localparam logic [3:0] S_OUT   = 4'd9;

  heap_entry_t     heap_mem [QUEUE_DEPTH];
  logic [31:0]     hs_mem   [TIMER_HANDLES];
  logic [TIMER_HANDLES-1:0] hs_vld_r;

  logic [3:0]      state_r;
  logic [63:0]     time_r;
  logic [31:0]     serial_r;
  logic [CW-1:0]   count_r;
  logic [AW-1:0]   pos_r;       // current slot of the moving entry
  heap_entry_t     cur_r;       // the moving entry
  heap_entry_t     left_r;
  out_beat_t       res_r;
  logic            ovld_r;

  // heap memory port
  logic            hwe;
  logic [AW-1:0]   hwa;
  heap_entry_t     hwd;
  logic [AW-1:0]   hra;
  heap_entry_t     hrd_r;
  logic            hs_we;
  logic [HW-1:0]   hs_wa;
  logic [31:0]     hs_wd;
  logic [HW-1:0]   hs_ra;
  logic [31:0]     hs_rd_r;
  logic            hs_rv_r;

  always_ff @(posedge clk) begin
    if (hwe) heap_mem[hwa] <= hwd;
    hrd_r <= heap_mem[hra];
    if (hs_we) hs_mem[hs_wa] <= hs_wd;
    hs_rd_r <= hs_mem[hs_ra];
  end

  function automatic logic earlier(heap_entry_t a, heap_entry_t b);
    if (a.deadline != b.deadline) return a.deadline < b.deadline;
    return a.serial < b.serial;
  endfunction

  in_beat_t ib;
  assign ib = in_ch.data;
  assign in_ch.ready = (state_r == S_IDLE) && !ovld_r;
  assign out_ch.valid = ovld_r;
  assign out_ch.data = res_r;

  logic [3:0]    state_nxt;
  logic [CW-1:0] count_nxt;
  logic [AW-1:0] pos_nxt;
  heap_entry_t   cur_nxt;
  heap_entry_t   left_nxt;
  logic [63:0]   time_nxt;
  logic [31:0]   serial_nxt;
  out_beat_t     res_nxt;
  logic          fin;
  logic [AW-1:0] par;
  logic [AW:0]   lch;
  logic [AW:0]   rch;
  logic [AW:0]   best;
  logic [31:0]   hs_cur;
  logic [31:0]   ser_inc;
  logic          hs_set;
  logic [HW-1:0] hs_idx;

  assign par  = AW'((pos_r - AW'(1)) >> 1);
  assign lch  = {pos_r, 1'b1};
  assign rch  = lch + (AW+1)'(1);
  assign hs_cur = hs_rv_r ? hs_rd_r : 32'd0;
  assign ser_inc = serial_r + 32'd1;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt = pos_r;
    cur_nxt = cur_r;
    left_nxt = left_r;
    time_nxt = time_r;
    serial_nxt = serial_r;
    res_nxt = res_r;
    fin = 1'b0;
    hwe = 1'b0;
    hwa = pos_r;
    hwd = cur_r;
    hra = '0;
    hs_we = 1'b0;
    hs_wa = '0;
    hs_wd = ser_inc;
    hs_ra = '0;
    hs_set = 1'b0;
    hs_idx = '0;
    best = '0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && !ovld_r) begin
          res_nxt = '0;
          res_nxt.fire_time = time_r;
          case (ib.cmd)
            CMD_INSERT: begin
              res_nxt.fired_timer = ib.timer_id;
              if (ib.delay_ms > MAX_SPAN_MS || ib.period_ms > MAX_SPAN_MS ||
                  count_r >= CW'(QUEUE_DEPTH) ||
                  32'(ib.timer_id) >= 32'(TIMER_HANDLES)) begin
                res_nxt.status = ST_REJECTED;
                fin = 1'b1;
              end else begin
                serial_nxt = ser_inc;
                hs_we = 1'b1;
                hs_wa = HW'(ib.timer_id);
                hs_set = 1'b1;
                hs_idx = HW'(ib.timer_id);
                res_nxt.status = ST_INSERTED;
                res_nxt.entry_serial = ser_inc;
                cur_nxt.deadline = time_r + 64'(ib.delay_ms);
                cur_nxt.period = ib.period_ms;
                cur_nxt.handle = ib.timer_id;
                cur_nxt.serial = ser_inc;
                pos_nxt = AW'(count_r);
                count_nxt = count_r + CW'(1);
                state_nxt = S_UPRD;
              end
            end
            CMD_TICK: begin
              time_nxt = time_r + 64'd1;
              res_nxt.fire_time = time_r + 64'd1;
              fin = 1'b1;
            end
            CMD_SERVICE: begin
              if (count_r == '0) fin = 1'b1;
              else begin
                hra = '0;
                state_nxt = S_SRD;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_UPRD: begin
        if (pos_r == '0) begin
          hwe = 1'b1;
          state_nxt = S_OUT;
        end else begin
          hra = par;
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (earlier(cur_r, hrd_r)) begin
          hwe = 1'b1;
          hwa = pos_r;
          hwd = hrd_r;
          pos_nxt = par;
          state_nxt = S_UPRD;
        end else begin
          hwe = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_SRD: begin
        cur_nxt = hrd_r;
        hs_ra = HW'(hrd_r.handle);
        if (hrd_r.deadline > time_r) begin
          fin = 1'b1;
        end else begin
          res_nxt.fired_timer = hrd_r.handle;
          res_nxt.entry_serial = hrd_r.serial;
          state_nxt = S_SHS;
        end
      end
      S_SHS: begin
        pos_nxt = '0;
        if (cur_r.serial != hs_cur || cur_r.period == '0) begin
          res_nxt.status = (cur_r.serial != hs_cur) ? ST_STALE : ST_ONESHOT;
          count_nxt = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            fin = 1'b1;
          end else begin
            hra = AW'(count_r - CW'(1));
            state_nxt = S_LAST;
          end
        end else begin
          res_nxt.status = ST_PERIODIC;
          cur_nxt.deadline = cur_r.deadline + 64'(cur_r.period);
          state_nxt = S_DNL;
        end
      end
      S_LAST: begin
        cur_nxt = hrd_r;
        state_nxt = S_DNL;
      end
      S_DNL: begin
        if (lch >= (AW+1)'(count_r)) begin
          hwe = 1'b1;
          state_nxt = S_OUT;
        end else begin
          hra = AW'(lch);
          state_nxt = S_DNR;
        end
      end
      S_DNR: begin
        left_nxt = hrd_r;
        hra = AW'(rch);
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        best = '0;
        if (earlier(left_r, cur_r)) best = lch;
        if (rch < (AW+1)'(count_r)) begin
          if (best == lch) begin
            if (earlier(hrd_r, left_r)) best = rch;
          end else if (earlier(hrd_r, cur_r)) best = rch;
        end
        if (best == '0) begin
          hwe = 1'b1;
          state_nxt = S_OUT;
        end else begin
          hwe = 1'b1;
          hwa = pos_r;
          hwd = (best == lch) ? left_r : hrd_r;
          pos_nxt = AW'(best);
          state_nxt = S_DNL;
        end
      end
      S_OUT: fin = 1'b1;
      default: state_nxt = S_IDLE;
    endcase
    if (fin) state_nxt = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      time_r <= '0;
      serial_r <= '0;
      count_r <= '0;
      hs_vld_r <= '0;
      hs_rv_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      time_r <= time_nxt;
      serial_r <= cfg_we ? cfg_wdata : serial_nxt;
      count_r <= count_nxt;
      if (hs_set) hs_vld_r[hs_idx] <= 1'b1;
      hs_rv_r <= hs_vld_r[hs_ra];
      if (fin) ovld_r <= 1'b1;
      else if (out_ch.ready) ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    cur_r <= cur_nxt;
    left_r <= left_nxt;
    res_r <= res_nxt;
  end
endmodule
`default_nettype wire
